FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top level RTL file of the mip level box downsampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mlbd_pkg.sv
// Package with the sizes, codes and types of the mip level box downsampler.
`timescale 1ns / 1ps

package mlbd_pkg;

    localparam int MAX_SOURCE_WIDTH  = 2048;
    localparam int MAX_SOURCE_HEIGHT = 2048;
    localparam int LINE_DEPTH        = (MAX_SOURCE_WIDTH + 1) / 2;

    localparam int COL_W  = $clog2(MAX_SOURCE_WIDTH);
    localparam int ROW_W  = $clog2(MAX_SOURCE_HEIGHT);
    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int DY_W   = ROW_W - 1;

    localparam int PIX_W      = 32;
    localparam int FMT_W      = 3;
    localparam int SIZE_W     = 12;
    localparam int TSIZE_W    = 11;
    localparam int CMP_W      = SIZE_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int CH_W   = 8;
    localparam int PSUM_W = 9;
    localparam int PCNT_W = 2;
    localparam int TSUM_W = 10;
    localparam int TCNT_W = 3;

    localparam logic [SIZE_W-1:0]  SW_MAX  = SIZE_W'(MAX_SOURCE_WIDTH);
    localparam logic [SIZE_W-1:0]  SH_MAX  = SIZE_W'(MAX_SOURCE_HEIGHT);
    localparam logic [TSIZE_W-1:0] TW_MAX  = TSIZE_W'(LINE_DEPTH);
    localparam logic [CH_W-1:0]    CH_FULL = 8'hff;
    localparam int                 CH_MAX  = 255;

    // Reciprocals for exact floored division of small products.
    localparam int RECIP31    = 8457;
    localparam int RECIP31_SH = 18;
    localparam int RECIP63    = 16645;
    localparam int RECIP63_SH = 20;
    localparam int RECIP3     = 683;
    localparam int RECIP3_SH  = 11;

    typedef enum logic [FMT_W-1:0] {
        FMT_ARGB8888 = 3'd0,
        FMT_XRGB8888 = 3'd1,
        FMT_RGB565   = 3'd2,
        FMT_ARGB4444 = 3'd3,
        FMT_A8       = 3'd4,
        FMT_L8       = 3'd5
    } t_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_FORMAT = 3'd0,
        REG_TARGET_FORMAT = 3'd1,
        REG_SOURCE_WIDTH  = 3'd2,
        REG_SOURCE_HEIGHT = 3'd3,
        REG_TARGET_WIDTH  = 3'd4,
        REG_TARGET_HEIGHT = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_pix;

    typedef struct packed {
        logic [PSUM_W-1:0] a;
        logic [PSUM_W-1:0] r;
        logic [PSUM_W-1:0] g;
        logic [PSUM_W-1:0] b;
        logic [PCNT_W-1:0] n;
    } t_psum;

    typedef struct packed {
        logic [TSUM_W-1:0] a;
        logic [TSUM_W-1:0] r;
        logic [TSUM_W-1:0] g;
        logic [TSUM_W-1:0] b;
        logic [TCNT_W-1:0] n;
    } t_tsum;

    typedef struct packed {
        logic              take;
        logic              x_odd;
        logic              y_odd;
        logic              pair_end;
        logic              close_row;
        logic              last;
        logic [ADDR_W-1:0] dx;
    } t_ctl;

endpackage

FILE: hw/rtl/mlbd_ifs.sv
// Valid/ready channel interfaces for pixels, results and register writes.
`timescale 1ns / 1ps

interface mlbd_pix_if;
    logic                         valid;
    logic                         ready;
    logic [mlbd_pkg::PIX_W-1:0]   source_pixel;

    modport source (output valid, output source_pixel, input ready);
    modport sink (input valid, input source_pixel, output ready);
endinterface

interface mlbd_res_if;
    logic                         valid;
    logic                         ready;
    logic [mlbd_pkg::PIX_W-1:0]   target_pixel;
    logic                         level_done;

    modport source (output valid, output target_pixel, output level_done, input ready);
    modport sink (input valid, input target_pixel, input level_done, output ready);
endinterface

interface mlbd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mlbd_pkg::CFG_IDX_W-1:0]    index;
    logic [mlbd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/mip_level_box_downsample.sv
// Top level of the 2x2 box filter that builds one mip level from the level above.
//
//   channel   dir   payload                      handshake
//   i_pix     in    source_pixel                 valid/ready, one request per cycle unless stalled
//   o_res     out   target_pixel, level_done     valid/ready, output register
//   i_cfg     in    index, data                  valid/ready, ready always high
//
// One request is accepted per cycle while the result is not stalled; its result, if any,
// passes through the four register stages (input, decode, line buffer sum, encode).
// Each request makes one line buffer read, with a two-entry write bypass.
// Reset is synchronous and active low; the line buffer needs no clearing pass.
// A stalled result freezes every stage and holds i_pix.ready low.
// Any write to one of the six mapped registers restarts the level at the first source pixel.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mip_level_box_downsample (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mlbd_pix_if.sink i_pix,
    mlbd_res_if.source o_res,
    mlbd_cfg_if.sink i_cfg
);

    function automatic logic [mlbd_pkg::CH_W-1:0] expand5(input logic [4:0] v);
        logic [26:0] prod;
        prod = 27'(v) * 27'(mlbd_pkg::CH_MAX * mlbd_pkg::RECIP31);
        return prod[mlbd_pkg::RECIP31_SH +: mlbd_pkg::CH_W];
    endfunction

    function automatic logic [mlbd_pkg::CH_W-1:0] expand6(input logic [5:0] v);
        logic [28:0] prod;
        prod = 29'(v) * 29'(mlbd_pkg::CH_MAX * mlbd_pkg::RECIP63);
        return prod[mlbd_pkg::RECIP63_SH +: mlbd_pkg::CH_W];
    endfunction

    // Floored division by 255 of a value below 2^14.
    function automatic logic [6:0] div255(input logic [13:0] x);
        logic [14:0] s;
        s = 15'(x) + 15'(x >> 8) + 15'(1);
        return s[14:8];
    endfunction

    function automatic logic [mlbd_pkg::CH_W-1:0] div3(input logic [9:0] s);
        logic [19:0] prod;
        prod = 20'(s) * 20'(mlbd_pkg::RECIP3);
        return prod[mlbd_pkg::RECIP3_SH +: mlbd_pkg::CH_W];
    endfunction

    function automatic logic [mlbd_pkg::SIZE_W-1:0] clamp_src(
        input logic [mlbd_pkg::SIZE_W-1:0] v,
        input logic [mlbd_pkg::SIZE_W-1:0] vmax
    );
        logic [mlbd_pkg::SIZE_W-1:0] res;
        if (v == '0) begin
            res = mlbd_pkg::SIZE_W'(1);
        end else if (v > vmax) begin
            res = vmax;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [mlbd_pkg::TSIZE_W-1:0] clamp_dst(
        input logic [mlbd_pkg::TSIZE_W-1:0] v,
        input logic [mlbd_pkg::TSIZE_W-1:0] vmax
    );
        logic [mlbd_pkg::TSIZE_W-1:0] res;
        if (v == '0) begin
            res = mlbd_pkg::TSIZE_W'(1);
        end else if (v > vmax) begin
            res = vmax;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic mlbd_pkg::t_pix decode(
        input logic [mlbd_pkg::FMT_W-1:0] fmt,
        input logic [mlbd_pkg::PIX_W-1:0] p
    );
        mlbd_pkg::t_pix c;
        c.a = mlbd_pkg::CH_FULL;
        case (fmt) inside
            mlbd_pkg::FMT_ARGB8888, mlbd_pkg::FMT_XRGB8888: begin
                c.r = p[7:0];
                c.g = p[15:8];
                c.b = p[23:16];
                if (fmt == mlbd_pkg::FMT_ARGB8888) begin
                    c.a = p[31:24];
                end
            end
            mlbd_pkg::FMT_RGB565, mlbd_pkg::FMT_ARGB4444: begin
                c.r = expand5(p[15:11]);
                c.g = expand6(p[10:5]);
                c.b = expand5(p[4:0]);
            end
            default: begin
                c.r = p[7:0];
                c.g = p[7:0];
                c.b = p[7:0];
            end
        endcase
        return c;
    endfunction

    function automatic logic [mlbd_pkg::PIX_W-1:0] encode(
        input logic [mlbd_pkg::FMT_W-1:0] fmt,
        input mlbd_pkg::t_pix p
    );
        logic [mlbd_pkg::PIX_W-1:0] e;
        logic [6:0]                 r5, g6, b5, a4, r4, g4, b4;
        r5 = div255(14'(p.r) * 14'(31));
        g6 = div255(14'(p.g) * 14'(63));
        b5 = div255(14'(p.b) * 14'(31));
        a4 = div255(14'(p.a) * 14'(15));
        r4 = div255(14'(p.r) * 14'(15));
        g4 = div255(14'(p.g) * 14'(15));
        b4 = div255(14'(p.b) * 14'(15));
        case (fmt)
            mlbd_pkg::FMT_ARGB8888: e = {p.a, p.b, p.g, p.r};
            mlbd_pkg::FMT_XRGB8888: e = {mlbd_pkg::CH_FULL, p.b, p.g, p.r};
            mlbd_pkg::FMT_RGB565:   e = {16'b0, r5[4:0], g6[5:0], b5[4:0]};
            mlbd_pkg::FMT_ARGB4444: e = {16'b0, a4[3:0], r4[3:0], g4[3:0], b4[3:0]};
            mlbd_pkg::FMT_A8:       e = {24'b0, p.a};
            mlbd_pkg::FMT_L8:       e = {24'b0, div3(10'(p.r) + 10'(p.g) + 10'(p.b))};
            default:                e = '0;
        endcase
        return e;
    endfunction

    // Configuration registers; the sizes are held already clamped to their legal ranges.
    logic [mlbd_pkg::FMT_W-1:0]   r_src_fmt, r_dst_fmt;
    logic [mlbd_pkg::SIZE_W-1:0]  r_sw, r_sh;
    logic [mlbd_pkg::TSIZE_W-1:0] r_tw, r_th;
    logic                         cfg_wr, restart;

    // Source position of the next request.
    logic [mlbd_pkg::COL_W-1:0] r_col, n_col;
    logic [mlbd_pkg::ROW_W-1:0] r_row, n_row;
    logic                       row_end, col_end;

    logic adv, accept;

    logic [mlbd_pkg::SIZE_W-1:0] lastx, lasty, tw_ext, th_ext, ex, ey;
    logic [mlbd_pkg::ADDR_W-1:0] dx;
    logic [mlbd_pkg::DY_W-1:0]   dy;
    logic                        fmt_ok;
    mlbd_pkg::t_ctl              s0_ctl;

    logic                       r_p1_valid;
    logic [mlbd_pkg::PIX_W-1:0] r_p1_pixel;
    mlbd_pkg::t_ctl             r_p1_ctl;

    logic           r_p2_valid;
    mlbd_pkg::t_pix r_p2_pix;
    mlbd_pkg::t_ctl r_p2_ctl;
    mlbd_pkg::t_psum r_p2_above;

    mlbd_pkg::t_psum r_rp, n_rp, above;
    mlbd_pkg::t_tsum tot;
    mlbd_pkg::t_pix  avg;
    logic [1:0]      avg_sh;
    logic            p2_wr, p2_emit;

    logic                        r_w1_valid, r_w2_valid;
    logic [mlbd_pkg::ADDR_W-1:0] r_w1_addr, r_w2_addr;
    mlbd_pkg::t_psum             r_w1_data, r_w2_data;

    logic [$bits(mlbd_pkg::t_psum)-1:0] ram_rd_data;

    logic           r_p3_valid;
    mlbd_pkg::t_pix r_p3_pix;
    logic           r_p3_last;

    logic                       r_out_valid;
    logic [mlbd_pkg::PIX_W-1:0] r_out_pixel;
    logic                       r_out_last;

    assign cfg_wr  = i_cfg.valid && i_cfg.ready;
    assign restart = cfg_wr && (i_cfg.index <= mlbd_pkg::REG_TARGET_HEIGHT);
    assign adv     = !(r_out_valid && !o_res.ready);
    assign accept  = i_pix.valid && adv;

    assign i_cfg.ready        = 1'b1;
    assign i_pix.ready        = adv;
    assign o_res.valid        = r_out_valid;
    assign o_res.target_pixel = r_out_pixel;
    assign o_res.level_done   = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= mlbd_pkg::FMT_ARGB8888;
            r_dst_fmt <= mlbd_pkg::FMT_ARGB8888;
            r_sw      <= mlbd_pkg::SIZE_W'(1);
            r_sh      <= mlbd_pkg::SIZE_W'(1);
            r_tw      <= mlbd_pkg::TSIZE_W'(1);
            r_th      <= mlbd_pkg::TSIZE_W'(1);
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                mlbd_pkg::REG_SOURCE_FORMAT: r_src_fmt <= i_cfg.data[mlbd_pkg::FMT_W-1:0];
                mlbd_pkg::REG_TARGET_FORMAT: r_dst_fmt <= i_cfg.data[mlbd_pkg::FMT_W-1:0];
                mlbd_pkg::REG_SOURCE_WIDTH:  r_sw <= clamp_src(i_cfg.data, mlbd_pkg::SW_MAX);
                mlbd_pkg::REG_SOURCE_HEIGHT: r_sh <= clamp_src(i_cfg.data, mlbd_pkg::SH_MAX);
                mlbd_pkg::REG_TARGET_WIDTH: begin
                    r_tw <= clamp_dst(i_cfg.data[mlbd_pkg::TSIZE_W-1:0], mlbd_pkg::TW_MAX);
                end
                mlbd_pkg::REG_TARGET_HEIGHT: begin
                    r_th <= clamp_dst(i_cfg.data[mlbd_pkg::TSIZE_W-1:0], '1);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        row_end = (mlbd_pkg::CMP_W'(r_col) + mlbd_pkg::CMP_W'(1)) == mlbd_pkg::CMP_W'(r_sw);
        col_end = (mlbd_pkg::CMP_W'(r_row) + mlbd_pkg::CMP_W'(1)) == mlbd_pkg::CMP_W'(r_sh);
        n_col   = r_col;
        n_row   = r_row;
        if (restart) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (row_end) begin
                n_col = '0;
                n_row = col_end ? '0 : r_row + mlbd_pkg::ROW_W'(1);
            end else begin
                n_col = r_col + mlbd_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Request classification from the current position and the level geometry.
    always_comb begin
        dx     = r_col[mlbd_pkg::COL_W-1:1];
        dy     = r_row[mlbd_pkg::ROW_W-1:1];
        tw_ext = mlbd_pkg::SIZE_W'(r_tw);
        th_ext = mlbd_pkg::SIZE_W'(r_th);
        lastx  = mlbd_pkg::SIZE_W'((mlbd_pkg::CMP_W'(r_sw) + mlbd_pkg::CMP_W'(1)) >> 1);
        lasty  = mlbd_pkg::SIZE_W'((mlbd_pkg::CMP_W'(r_sh) + mlbd_pkg::CMP_W'(1)) >> 1);
        ex     = ((lastx < tw_ext) ? lastx : tw_ext) - mlbd_pkg::SIZE_W'(1);
        ey     = ((lasty < th_ext) ? lasty : th_ext) - mlbd_pkg::SIZE_W'(1);
        fmt_ok = (r_src_fmt <= mlbd_pkg::FMT_L8) && (r_dst_fmt <= mlbd_pkg::FMT_L8);

        s0_ctl.take      = fmt_ok && (mlbd_pkg::SIZE_W'(dx) < tw_ext)
                           && (mlbd_pkg::SIZE_W'(dy) < th_ext);
        s0_ctl.x_odd     = r_col[0];
        s0_ctl.y_odd     = r_row[0];
        s0_ctl.pair_end  = r_col[0] || row_end;
        s0_ctl.close_row = r_row[0] || col_end;
        s0_ctl.last      = (mlbd_pkg::SIZE_W'(dx) == ex) && (mlbd_pkg::SIZE_W'(dy) == ey);
        s0_ctl.dx        = dx;
    end

    mlbd_ram #(
        .WIDTH ($bits(mlbd_pkg::t_psum)),
        .DEPTH (mlbd_pkg::LINE_DEPTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (p2_wr),
        .i_wr_addr (r_p2_ctl.dx),
        .i_wr_data (n_rp),
        .i_rd_en   (accept),
        .i_rd_addr (dx),
        .o_rd_data (ram_rd_data)
    );

    // Upper row sums: the newest of the last two writes wins over the RAM read.
    always_comb begin
        if (r_w1_valid && (r_w1_addr == r_p2_ctl.dx)) begin
            above = r_w1_data;
        end else if (r_w2_valid && (r_w2_addr == r_p2_ctl.dx)) begin
            above = r_w2_data;
        end else begin
            above = r_p2_above;
        end

        if (r_p2_ctl.x_odd) begin
            n_rp.a = r_rp.a + mlbd_pkg::PSUM_W'(r_p2_pix.a);
            n_rp.r = r_rp.r + mlbd_pkg::PSUM_W'(r_p2_pix.r);
            n_rp.g = r_rp.g + mlbd_pkg::PSUM_W'(r_p2_pix.g);
            n_rp.b = r_rp.b + mlbd_pkg::PSUM_W'(r_p2_pix.b);
            n_rp.n = r_rp.n + mlbd_pkg::PCNT_W'(1);
        end else begin
            n_rp.a = mlbd_pkg::PSUM_W'(r_p2_pix.a);
            n_rp.r = mlbd_pkg::PSUM_W'(r_p2_pix.r);
            n_rp.g = mlbd_pkg::PSUM_W'(r_p2_pix.g);
            n_rp.b = mlbd_pkg::PSUM_W'(r_p2_pix.b);
            n_rp.n = mlbd_pkg::PCNT_W'(1);
        end

        tot.a = mlbd_pkg::TSUM_W'(n_rp.a);
        tot.r = mlbd_pkg::TSUM_W'(n_rp.r);
        tot.g = mlbd_pkg::TSUM_W'(n_rp.g);
        tot.b = mlbd_pkg::TSUM_W'(n_rp.b);
        tot.n = mlbd_pkg::TCNT_W'(n_rp.n);
        if (r_p2_ctl.y_odd) begin
            tot.a = tot.a + mlbd_pkg::TSUM_W'(above.a);
            tot.r = tot.r + mlbd_pkg::TSUM_W'(above.r);
            tot.g = tot.g + mlbd_pkg::TSUM_W'(above.g);
            tot.b = tot.b + mlbd_pkg::TSUM_W'(above.b);
            tot.n = tot.n + mlbd_pkg::TCNT_W'(above.n);
        end

        case (tot.n)
            3'd4:    avg_sh = 2'd2;
            3'd2:    avg_sh = 2'd1;
            default: avg_sh = 2'd0;
        endcase
        avg.a = mlbd_pkg::CH_W'(tot.a >> avg_sh);
        avg.r = mlbd_pkg::CH_W'(tot.r >> avg_sh);
        avg.g = mlbd_pkg::CH_W'(tot.g >> avg_sh);
        avg.b = mlbd_pkg::CH_W'(tot.b >> avg_sh);

        p2_wr   = adv && r_p2_valid && r_p2_ctl.take && r_p2_ctl.pair_end && !r_p2_ctl.y_odd;
        p2_emit = r_p2_valid && r_p2_ctl.take && r_p2_ctl.pair_end && r_p2_ctl.close_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_w1_valid  <= 1'b0;
            r_w2_valid  <= 1'b0;
        end else begin
            if (adv) begin
                r_p1_valid  <= accept;
                r_p2_valid  <= r_p1_valid;
                r_p3_valid  <= p2_emit;
                r_out_valid <= r_p3_valid;
            end
            if (p2_wr) begin
                r_w1_valid <= 1'b1;
                r_w2_valid <= r_w1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_pixel  <= i_pix.source_pixel;
            r_p1_ctl    <= s0_ctl;
            r_p2_pix    <= decode(r_src_fmt, r_p1_pixel);
            r_p2_ctl    <= r_p1_ctl;
            r_p2_above  <= ram_rd_data;
            r_p3_pix    <= avg;
            r_p3_last   <= r_p2_ctl.last;
            r_out_pixel <= encode(r_dst_fmt, r_p3_pix);
            r_out_last  <= r_p3_last;
            if (r_p2_valid && r_p2_ctl.take) begin
                r_rp <= n_rp;
            end
        end
        if (p2_wr) begin
            r_w1_addr <= r_p2_ctl.dx;
            r_w1_data <= n_rp;
            r_w2_addr <= r_w1_addr;
            r_w2_data <= r_w1_data;
        end
    end

    `ASSERT_IMPLIES(a_stall_holds_input, i_clk, i_rst_n, r_out_valid && !o_res.ready, !i_pix.ready, "request taken while the result is stalled")
    `ASSERT_IMPLIES(a_col_in_row, i_clk, i_rst_n, 1'b1, mlbd_pkg::CMP_W'(r_col) < mlbd_pkg::CMP_W'(r_sw), "column counter beyond source width")
    `ASSERT_IMPLIES(a_row_in_level, i_clk, i_rst_n, 1'b1, mlbd_pkg::CMP_W'(r_row) < mlbd_pkg::CMP_W'(r_sh), "row counter beyond source height")
    `ASSERT_IMPLIES(a_above_in_step, i_clk, i_rst_n, r_p2_valid && r_p2_ctl.take && r_p2_ctl.pair_end && r_p2_ctl.y_odd, above.n == n_rp.n, "line buffer entry out of step with the current pair")

endmodule

FILE: hw/rtl/mlbd_ram.sv
// Generic simple dual port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module mlbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: tb/tb.sv
// Testbench that streams source texels through the box downsampler and checks each result.
`timescale 1ns / 1ps

module tb;

    localparam int                             PIPE_SLACK       = 12;
    localparam int                             RANDOM_ITEMS     = 400;
    localparam int                             WIDE_ITEMS       = 32;
    localparam longint unsigned                CYCLE_LIMIT      = 2000000;
    localparam int                             SHOWN_MISMATCHES = 10;
    localparam logic [mlbd_pkg::CFG_IDX_W-1:0] REG_SPARE        = 3'd7;
    localparam logic [mlbd_pkg::FMT_W-1:0]     FMT_UNUSED6      = 3'd6;
    localparam logic [mlbd_pkg::FMT_W-1:0]     FMT_UNUSED7      = 3'd7;

    typedef struct {
        int unsigned a, r, g, b, n;
    } t_chan_sums;

    typedef struct {
        logic [mlbd_pkg::PIX_W-1:0] pixel;
        logic                       done;
    } t_target_item;

    typedef struct {
        logic [mlbd_pkg::CFG_IDX_W-1:0]  index;
        logic [mlbd_pkg::CFG_DATA_W-1:0] data;
    } t_reg_write;

    typedef t_reg_write t_write_list[$];

    class downsample_scoreboard;
        logic [mlbd_pkg::FMT_W-1:0]   src_fmt, tgt_fmt;
        logic [mlbd_pkg::SIZE_W-1:0]  src_w, src_h;
        logic [mlbd_pkg::TSIZE_W-1:0] tgt_w, tgt_h;
        t_chan_sums                   upper_row [mlbd_pkg::LINE_DEPTH];
        t_chan_sums                   pair_sum;
        int unsigned                  col, row;
        t_target_item                 pending_pixels [$];
        int                           mismatches;
        int                           results_seen;

        function new();
            src_fmt = mlbd_pkg::FMT_ARGB8888;
            tgt_fmt = mlbd_pkg::FMT_ARGB8888;
            src_w = 1;
            src_h = 1;
            tgt_w = 1;
            tgt_h = 1;
            foreach (upper_row[i]) upper_row[i] = '{default: 0};
            mismatches = 0;
            results_seen = 0;
            restart_level();
        endfunction

        function void restart_level();
            pair_sum = '{default: 0};
            col = 0;
            row = 0;
        endfunction

        function int unsigned fit_size(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES) $display("%s", msg);
        endfunction

        function void note_register(logic [mlbd_pkg::CFG_IDX_W-1:0] index,
                                    logic [mlbd_pkg::CFG_DATA_W-1:0] data);
            case (index)
                mlbd_pkg::REG_SOURCE_FORMAT: src_fmt = data[mlbd_pkg::FMT_W-1:0];
                mlbd_pkg::REG_TARGET_FORMAT: tgt_fmt = data[mlbd_pkg::FMT_W-1:0];
                mlbd_pkg::REG_SOURCE_WIDTH:  src_w = data[mlbd_pkg::SIZE_W-1:0];
                mlbd_pkg::REG_SOURCE_HEIGHT: src_h = data[mlbd_pkg::SIZE_W-1:0];
                mlbd_pkg::REG_TARGET_WIDTH:  tgt_w = data[mlbd_pkg::TSIZE_W-1:0];
                mlbd_pkg::REG_TARGET_HEIGHT: tgt_h = data[mlbd_pkg::TSIZE_W-1:0];
                default: return;
            endcase
            restart_level();
        endfunction

        function bit decode_texel(logic [mlbd_pkg::PIX_W-1:0] p, output t_chan_sums c);
            c.n = 1;
            c.a = mlbd_pkg::CH_MAX;
            case (src_fmt)
                mlbd_pkg::FMT_ARGB8888, mlbd_pkg::FMT_XRGB8888: begin
                    c.r = p[7:0];
                    c.g = p[15:8];
                    c.b = p[23:16];
                    if (src_fmt == mlbd_pkg::FMT_ARGB8888) c.a = p[31:24];
                end
                mlbd_pkg::FMT_RGB565, mlbd_pkg::FMT_ARGB4444: begin
                    c.r = p[15:11] * mlbd_pkg::CH_MAX / 31;
                    c.g = p[10:5] * mlbd_pkg::CH_MAX / 63;
                    c.b = p[4:0] * mlbd_pkg::CH_MAX / 31;
                end
                mlbd_pkg::FMT_A8, mlbd_pkg::FMT_L8: begin
                    c.r = p[7:0];
                    c.g = p[7:0];
                    c.b = p[7:0];
                end
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function logic [mlbd_pkg::PIX_W-1:0] encode_texel(int unsigned a, int unsigned r,
                                                          int unsigned g, int unsigned b);
            case (tgt_fmt)
                mlbd_pkg::FMT_ARGB8888: return {a[7:0], b[7:0], g[7:0], r[7:0]};
                mlbd_pkg::FMT_XRGB8888: return {mlbd_pkg::CH_FULL, b[7:0], g[7:0], r[7:0]};
                mlbd_pkg::FMT_RGB565:
                    return mlbd_pkg::PIX_W'(((r * 31 / mlbd_pkg::CH_MAX) << 11) |
                                            ((g * 63 / mlbd_pkg::CH_MAX) << 5) |
                                            (b * 31 / mlbd_pkg::CH_MAX));
                mlbd_pkg::FMT_ARGB4444:
                    return mlbd_pkg::PIX_W'(((a * 15 / mlbd_pkg::CH_MAX) << 12) |
                                            ((r * 15 / mlbd_pkg::CH_MAX) << 8) |
                                            ((g * 15 / mlbd_pkg::CH_MAX) << 4) |
                                            (b * 15 / mlbd_pkg::CH_MAX));
                mlbd_pkg::FMT_A8:       return mlbd_pkg::PIX_W'(a);
                mlbd_pkg::FMT_L8:       return mlbd_pkg::PIX_W'((r + g + b) / 3);
                default:                return '0;
            endcase
        endfunction

        function void note_source_pixel(logic [mlbd_pkg::PIX_W-1:0] p);
            int unsigned  sw, sh, tw, th, dx, dy, ex, ey;
            t_chan_sums   c, t;
            bit           ok, close;
            t_target_item item;
            sw = fit_size(src_w, mlbd_pkg::MAX_SOURCE_WIDTH);
            sh = fit_size(src_h, mlbd_pkg::MAX_SOURCE_HEIGHT);
            tw = fit_size(tgt_w, mlbd_pkg::LINE_DEPTH);
            th = fit_size(tgt_h, 32'hffff_ffff);
            dx = col >> 1;
            dy = row >> 1;
            ok = decode_texel(p, c) && (tgt_fmt <= mlbd_pkg::FMT_L8);
            if (ok && dx < tw && dy < th) begin
                if (!col[0]) begin
                    pair_sum = c;
                end else begin
                    pair_sum.a += c.a;
                    pair_sum.r += c.r;
                    pair_sum.g += c.g;
                    pair_sum.b += c.b;
                    pair_sum.n += 1;
                end
                if (col[0] || col + 1 == sw) begin
                    t = pair_sum;
                    if (!row[0]) begin
                        upper_row[dx] = pair_sum;
                        close = (row + 1 == sh);
                    end else begin
                        t.a += upper_row[dx].a;
                        t.r += upper_row[dx].r;
                        t.g += upper_row[dx].g;
                        t.b += upper_row[dx].b;
                        t.n += upper_row[dx].n;
                        close = 1'b1;
                    end
                    if (close && t.n != 0) begin
                        ex = (((sw + 1) / 2 < tw) ? (sw + 1) / 2 : tw) - 1;
                        ey = (((sh + 1) / 2 < th) ? (sh + 1) / 2 : th) - 1;
                        item.pixel = encode_texel(t.a / t.n, t.r / t.n, t.g / t.n, t.b / t.n);
                        item.done = (dx == ex && dy == ey);
                        pending_pixels.push_back(item);
                    end
                end
            end
            col++;
            if (col >= sw) begin
                col = 0;
                row++;
                if (row >= sh) row = 0;
            end
        endfunction

        function void check_target_pixel(logic [mlbd_pkg::PIX_W-1:0] pixel, logic done);
            t_target_item want;
            results_seen++;
            if (pending_pixels.size() == 0) begin
                flag($sformatf("result %0d: unexpected pixel %h done %b",
                               results_seen, pixel, done));
                return;
            end
            want = pending_pixels.pop_front();
            if (pixel !== want.pixel)
                flag($sformatf("result %0d: target_pixel got %h, expected %h",
                               results_seen, pixel, want.pixel));
            if (done !== want.done)
                flag($sformatf("result %0d: level_done got %b, expected %b",
                               results_seen, done, want.done));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mlbd_pix_if pix ();
    mlbd_res_if res ();
    mlbd_cfg_if cfg ();

    mip_level_box_downsample dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    downsample_scoreboard sb = new();

    longint unsigned cycles = 0;
    int unsigned     ready_run = 0;
    bit              ready_level = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Result back-pressure: long ready stretches, short stalls, and a few long ones.
    always @(posedge i_clk) begin
        if (ready_run == 0) begin
            ready_level = ($urandom_range(0, 3) != 0);
            if (ready_level)
                ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(1, 12);
            else
                ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
        end
        ready_run--;
        res.ready <= ready_level;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg.valid && cfg.ready) sb.note_register(cfg.index, cfg.data);
            if (pix.valid && pix.ready) sb.note_source_pixel(pix.source_pixel);
            if (res.valid && res.ready) sb.check_target_pixel(res.target_pixel, res.level_done);
        end
    end

    function automatic int unsigned pick_gap(bit steady);
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_write_list full_config(logic [mlbd_pkg::FMT_W-1:0] sf,
                                                logic [mlbd_pkg::FMT_W-1:0] tf,
                                                logic [mlbd_pkg::CFG_DATA_W-1:0] sw,
                                                logic [mlbd_pkg::CFG_DATA_W-1:0] sh,
                                                logic [mlbd_pkg::CFG_DATA_W-1:0] tw,
                                                logic [mlbd_pkg::CFG_DATA_W-1:0] th);
        t_write_list w;
        w.push_back('{mlbd_pkg::REG_SOURCE_FORMAT,
                      {(mlbd_pkg::CFG_DATA_W-mlbd_pkg::FMT_W)'($urandom()), sf}});
        w.push_back('{mlbd_pkg::REG_TARGET_FORMAT,
                      {(mlbd_pkg::CFG_DATA_W-mlbd_pkg::FMT_W)'($urandom()), tf}});
        w.push_back('{mlbd_pkg::REG_SOURCE_WIDTH, sw});
        w.push_back('{mlbd_pkg::REG_SOURCE_HEIGHT, sh});
        w.push_back('{mlbd_pkg::REG_TARGET_WIDTH, tw});
        w.push_back('{mlbd_pkg::REG_TARGET_HEIGHT, th});
        return w;
    endfunction

    // Items with no result can still be in flight once the last result is out.
    task automatic wait_idle();
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    task automatic run_phase(input t_write_list writes, input int unsigned count,
                             input bit steady, input bit extremes_first);
        int unsigned                gap;
        logic [mlbd_pkg::PIX_W-1:0] value;
        wait_idle();
        foreach (writes[i]) begin
            cfg.valid <= 1'b1;
            cfg.index <= writes[i].index;
            cfg.data <= writes[i].data;
            @(posedge i_clk);
            while (!cfg.ready) @(posedge i_clk);
        end
        cfg.valid <= 1'b0;
        for (int unsigned k = 0; k < count; k++) begin
            gap = pick_gap(steady);
            case ($urandom_range(0, 7))
                0: value = '0;
                1: value = '1;
                default: value = $urandom();
            endcase
            if (extremes_first && k == 0) value = '0;
            if (extremes_first && k == 1) value = '1;
            if (gap != 0) begin
                pix.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pix.valid <= 1'b1;
            pix.source_pixel <= value;
            @(posedge i_clk);
            while (!pix.ready) @(posedge i_clk);
        end
        pix.valid <= 1'b0;
    endtask

    initial begin
        t_write_list plan;
        t_write_list none;
        int unsigned random_sent;
        int unsigned sw, sh, tw, th, level, count;
        int unsigned cur_sw, cur_sh;

        i_rst_n <= 1'b0;
        pix.valid <= 1'b0;
        pix.source_pixel <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= mlbd_pkg::REG_SOURCE_FORMAT;
        cfg.data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_phase(none, 2, 1'b0, 1'b1);
        run_phase(full_config(mlbd_pkg::FMT_ARGB8888, mlbd_pkg::FMT_XRGB8888, 2, 2, 1, 1),
                  4, 1'b0, 1'b1);
        run_phase(full_config(mlbd_pkg::FMT_XRGB8888, mlbd_pkg::FMT_RGB565, 3, 1, 2, 1),
                  3, 1'b0, 1'b1);
        run_phase(full_config(mlbd_pkg::FMT_RGB565, mlbd_pkg::FMT_ARGB4444, 2, 3, 1, 2),
                  6, 1'b0, 1'b1);
        run_phase(full_config(mlbd_pkg::FMT_ARGB4444, mlbd_pkg::FMT_A8, 4, 2, 1, 1),
                  8, 1'b0, 1'b1);
        run_phase(full_config(mlbd_pkg::FMT_A8, mlbd_pkg::FMT_L8, 1, 1, 1, 1),
                  1, 1'b0, 1'b1);
        run_phase(full_config(mlbd_pkg::FMT_L8, mlbd_pkg::FMT_ARGB8888, 2, 2, 1, 1),
                  4, 1'b1, 1'b1);

        run_phase(full_config(mlbd_pkg::FMT_ARGB8888, mlbd_pkg::FMT_ARGB8888,
                              12'hfff, 1, 12'hfff, 1),
                  WIDE_ITEMS, 1'b0, 1'b1);
        run_phase(full_config(mlbd_pkg::FMT_RGB565, mlbd_pkg::FMT_L8,
                              1, 12'hfff, 1, 12'h400),
                  WIDE_ITEMS, 1'b0, 1'b1);
        run_phase(full_config(mlbd_pkg::FMT_XRGB8888, mlbd_pkg::FMT_ARGB4444, 0, 0, 0, 0),
                  3, 1'b0, 1'b1);
        run_phase(full_config(FMT_UNUSED7, mlbd_pkg::FMT_ARGB8888, 2, 2, 1, 1),
                  4, 1'b0, 1'b1);
        run_phase(full_config(mlbd_pkg::FMT_A8, FMT_UNUSED6, 2, 2, 1, 1),
                  4, 1'b0, 1'b1);

        cur_sw = 2;
        cur_sh = 2;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            plan = {};
            case ($urandom_range(0, 19))
                0: sw = 0;
                1: sw = $urandom_range(11, 40);
                default: sw = $urandom_range(1, 10);
            endcase
            case ($urandom_range(0, 19))
                0: sh = 0;
                1: sh = $urandom_range(9, 16);
                default: sh = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 19))
                0: tw = 0;
                1: tw = ($urandom_range(0, 1) == 0) ? mlbd_pkg::LINE_DEPTH
                                                     : $urandom_range(0, 4095);
                2, 3, 4, 5, 6, 7, 8, 9: tw = $urandom_range(1, 6);
                default: tw = (sw + 1) / 2;
            endcase
            case ($urandom_range(0, 19))
                0: th = 0;
                1: th = ($urandom_range(0, 1) == 0) ? mlbd_pkg::LINE_DEPTH
                                                     : $urandom_range(0, 4095);
                2, 3, 4, 5, 6, 7, 8, 9: th = $urandom_range(1, 6);
                default: th = (sh + 1) / 2;
            endcase
            if ($urandom_range(0, 1) == 0)
                plan.push_back('{mlbd_pkg::REG_SOURCE_FORMAT,
                    {(mlbd_pkg::CFG_DATA_W-mlbd_pkg::FMT_W)'($urandom()),
                     ($urandom_range(0, 9) == 0)
                         ? FMT_UNUSED6 + mlbd_pkg::FMT_W'($urandom_range(0, 1))
                         : mlbd_pkg::FMT_W'($urandom_range(0, 5))}});
            if ($urandom_range(0, 1) == 0)
                plan.push_back('{mlbd_pkg::REG_TARGET_FORMAT,
                    {(mlbd_pkg::CFG_DATA_W-mlbd_pkg::FMT_W)'($urandom()),
                     ($urandom_range(0, 9) == 0)
                         ? FMT_UNUSED6 + mlbd_pkg::FMT_W'($urandom_range(0, 1))
                         : mlbd_pkg::FMT_W'($urandom_range(0, 5))}});
            if ($urandom_range(0, 1) == 0) begin
                plan.push_back('{mlbd_pkg::REG_SOURCE_WIDTH, mlbd_pkg::CFG_DATA_W'(sw)});
                cur_sw = sw;
            end
            if ($urandom_range(0, 1) == 0) begin
                plan.push_back('{mlbd_pkg::REG_SOURCE_HEIGHT, mlbd_pkg::CFG_DATA_W'(sh)});
                cur_sh = sh;
            end
            if ($urandom_range(0, 1) == 0)
                plan.push_back('{mlbd_pkg::REG_TARGET_WIDTH,
                                 {$urandom_range(0, 1) == 1, tw[10:0]}});
            if ($urandom_range(0, 1) == 0)
                plan.push_back('{mlbd_pkg::REG_TARGET_HEIGHT,
                                 {$urandom_range(0, 1) == 1, th[10:0]}});
            // A write to an unmapped index must leave the level running.
            if ($urandom_range(0, 19) == 0)
                plan.push_back('{REG_SPARE, mlbd_pkg::CFG_DATA_W'($urandom())});
            level = sb.fit_size(cur_sw, mlbd_pkg::MAX_SOURCE_WIDTH)
                    * sb.fit_size(cur_sh, mlbd_pkg::MAX_SOURCE_HEIGHT);
            if ($urandom_range(0, 9) < 7)
                count = level * $urandom_range(1, 2);
            else
                count = $urandom_range(1, level + 3);
            if (count > RANDOM_ITEMS - random_sent)
                count = RANDOM_ITEMS - random_sent;
            run_phase(plan, count, $urandom_range(0, 3) == 0, 1'b0);
            random_sent += count;
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mlbd_pkg.sv
hw/rtl/mlbd_ifs.sv
hw/rtl/mlbd_ram.sv
hw/rtl/mip_level_box_downsample.sv
tb/tb.sv
